// ===== rtl/core/ufp_pkg.sv =====
// Package for the binary frame parser: word types for the input and result
// channels, parser phase encoding and protocol constants. No dependencies.
`default_nettype none

package ufp_pkg;

    localparam logic [7:0]  SYNC1      = 8'hB5;
    localparam logic [7:0]  SYNC2      = 8'h62;
    localparam logic [15:0] ACK_ID_NAK = 16'h0500;
    localparam logic [15:0] ACK_ID_ACK = 16'h0501;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_SYNC1   = 4'd1,
        PH_SYNC2   = 4'd2,
        PH_CLASS   = 4'd3,
        PH_ID      = 4'd4,
        PH_LEN_LO  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CK_A    = 4'd7,
        PH_CK_B    = 4'd8
    } phase_t;

    typedef enum logic {
        FUNC_DATA    = 1'b0,
        FUNC_RESTART = 1'b1
    } func_t;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  parse_state;
        logic        frame_ok;
        logic        checksum_fail;
        logic [15:0] message_id;
        logic [15:0] frame_length;
        logic        payload_valid;
        logic [15:0] payload_index;
        logic [7:0]  payload_byte;
        logic        is_ack_frame;
        logic [15:0] acked_id;
    } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/core/ufp_stream_if.sv =====
// Valid/ready stream channel carrying one word of a given packed type.
// Used for both the byte input and the result output of the frame parser.
`default_nettype none

interface ufp_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ubx_frame_parser_unit.sv =====
// Binary frame parser top level: sync, header, Fletcher check and payload
// streaming. Depends on ufp_pkg and ufp_stream_if.
//
// Usage:
// - rx_ch (sink, data type ufp_pkg::in_word_t) takes one word per received
//   byte; func selects byte processing or a restart to idle.
// - res_ch (source, data type ufp_pkg::out_word_t) returns exactly one
//   result word for every accepted input word, in order.
// - The result is registered: a word accepted at an edge has its result
//   valid after that edge. Throughput is one word per cycle while res_ch
//   is ready; parser state and Fletcher sums update in one step per byte.
// - The result sits in an output register. A new input word is taken
//   whenever that register is empty or is being drained in the same cycle,
//   so a stalled receiver holds the result and back-pressures rx_ch.
// - Reset (rst_n low, asynchronous) returns the parser to idle, clears
//   sums, ids, lengths and the acknowledge word, and empties the output.
`default_nettype none

module ubx_frame_parser_unit (
    input  wire logic     clk,
    input  wire logic     rst_n,
    ufp_stream_if.sink    rx_ch,
    ufp_stream_if.source  res_ch
);

    ufp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [15:0] frame_id_reg, frame_id_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] byte_position_reg, byte_position_next;
    logic [15:0] last_length_reg, last_length_next;
    logic [15:0] ack_word_reg, ack_word_next;

    logic                 out_valid_reg;
    ufp_pkg::out_word_t   out_data_reg;
    ufp_pkg::out_word_t   result;

    logic        accept;
    logic        restart;
    logic [7:0]  b;
    logic        ack_cur;
    logic        ack_new;
    logic [7:0]  acc_a;
    logic [7:0]  acc_b;
    logic [15:0] len_full;
    logic [15:0] left_dec;
    logic        ok;
    logic        fail;
    logic        pv;

    assign rx_ch.ready  = !out_valid_reg || res_ch.ready;
    assign accept       = rx_ch.valid && rx_ch.ready;
    assign restart      = (rx_ch.data.func == ufp_pkg::FUNC_RESTART);
    assign b            = rx_ch.data.rx_byte;
    assign res_ch.valid = out_valid_reg;
    assign res_ch.data  = out_data_reg;

    assign ack_cur  = (frame_id_reg == ufp_pkg::ACK_ID_NAK)
                   || (frame_id_reg == ufp_pkg::ACK_ID_ACK);
    assign ack_new  = (frame_id_next == ufp_pkg::ACK_ID_NAK)
                   || (frame_id_next == ufp_pkg::ACK_ID_ACK);
    assign acc_a    = sum_a_reg + b;
    assign acc_b    = sum_b_reg + acc_a;
    assign len_full = {b, bytes_left_reg[7:0]};
    assign left_dec = bytes_left_reg - 16'd1;

    // Phase transitions.
    always_comb
    begin
        phase_next = phase_reg;
        if (restart)
        begin
            phase_next = ufp_pkg::PH_IDLE;
        end
        else
        begin
            case (phase_reg)
                ufp_pkg::PH_SYNC1:
                    phase_next = (b == ufp_pkg::SYNC2) ? ufp_pkg::PH_SYNC2 : ufp_pkg::PH_IDLE;
                ufp_pkg::PH_SYNC2:
                    phase_next = ufp_pkg::PH_CLASS;
                ufp_pkg::PH_CLASS:
                    phase_next = ufp_pkg::PH_ID;
                ufp_pkg::PH_ID:
                    phase_next = ufp_pkg::PH_LEN_LO;
                ufp_pkg::PH_LEN_LO:
                    phase_next = (len_full == 16'd0) ? ufp_pkg::PH_CK_A : ufp_pkg::PH_PAYLOAD;
                ufp_pkg::PH_PAYLOAD:
                    phase_next = (left_dec == 16'd0) ? ufp_pkg::PH_CK_A : ufp_pkg::PH_PAYLOAD;
                ufp_pkg::PH_CK_A:
                    phase_next = (b == sum_a_reg) ? ufp_pkg::PH_CK_B : ufp_pkg::PH_IDLE;
                ufp_pkg::PH_CK_B:
                    phase_next = ufp_pkg::PH_IDLE;
                default:
                    phase_next = (b == ufp_pkg::SYNC1) ? ufp_pkg::PH_SYNC1 : ufp_pkg::PH_IDLE;
            endcase
        end
    end

    // Datapath and result flags.
    always_comb
    begin
        sum_a_next         = sum_a_reg;
        sum_b_next         = sum_b_reg;
        frame_id_next      = frame_id_reg;
        bytes_left_next    = bytes_left_reg;
        byte_position_next = byte_position_reg;
        last_length_next   = last_length_reg;
        ack_word_next      = ack_word_reg;
        ok                 = 1'b0;
        fail               = 1'b0;
        pv                 = 1'b0;
        if (!restart)
        begin
            case (phase_reg)
                ufp_pkg::PH_SYNC2:
                begin
                    sum_a_next    = b;
                    sum_b_next    = b;
                    frame_id_next = {b, 8'h00};
                end
                ufp_pkg::PH_CLASS:
                begin
                    sum_a_next    = acc_a;
                    sum_b_next    = acc_b;
                    frame_id_next = {frame_id_reg[15:8], b};
                end
                ufp_pkg::PH_ID:
                begin
                    sum_a_next      = acc_a;
                    sum_b_next      = acc_b;
                    bytes_left_next = {8'h00, b};
                end
                ufp_pkg::PH_LEN_LO:
                begin
                    sum_a_next         = acc_a;
                    sum_b_next         = acc_b;
                    bytes_left_next    = len_full;
                    byte_position_next = 16'd0;
                    if (!ack_cur)
                    begin
                        last_length_next = len_full;
                    end
                end
                ufp_pkg::PH_PAYLOAD:
                begin
                    sum_a_next = acc_a;
                    sum_b_next = acc_b;
                    if (ack_cur)
                    begin
                        // Only the first two payload bytes form the acknowledged id.
                        if (byte_position_reg == 16'd0)
                        begin
                            ack_word_next = {b, ack_word_reg[7:0]};
                        end
                        else if (byte_position_reg == 16'd1)
                        begin
                            ack_word_next = {ack_word_reg[15:8], b};
                        end
                    end
                    else
                    begin
                        pv = 1'b1;
                    end
                    byte_position_next = byte_position_reg + 16'd1;
                    bytes_left_next    = left_dec;
                end
                ufp_pkg::PH_CK_A:
                begin
                    fail = (b != sum_a_reg);
                end
                ufp_pkg::PH_CK_B:
                begin
                    ok   = (b == sum_b_reg);
                    fail = (b != sum_b_reg);
                end
                default:
                begin
                end
            endcase
        end

        result.parse_state   = phase_next;
        result.frame_ok      = ok;
        result.checksum_fail = fail;
        result.message_id    = frame_id_next;
        result.frame_length  = last_length_next;
        result.payload_valid = pv;
        result.payload_index = pv ? byte_position_reg : 16'd0;
        result.payload_byte  = pv ? b : 8'd0;
        result.is_ack_frame  = ack_new;
        result.acked_id      = ack_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= ufp_pkg::PH_IDLE;
            sum_a_reg         <= 8'd0;
            sum_b_reg         <= 8'd0;
            frame_id_reg      <= 16'd0;
            bytes_left_reg    <= 16'd0;
            byte_position_reg <= 16'd0;
            last_length_reg   <= 16'd0;
            ack_word_reg      <= 16'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg         <= phase_next;
                sum_a_reg         <= sum_a_next;
                sum_b_reg         <= sum_b_next;
                frame_id_reg      <= frame_id_next;
                bytes_left_reg    <= bytes_left_next;
                byte_position_reg <= byte_position_next;
                last_length_reg   <= last_length_next;
                ack_word_reg      <= ack_word_next;
                out_valid_reg     <= 1'b1;
            end
            else if (res_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for ubx_frame_parser_unit: directed and random byte streams with random idle
// cycles on both channels, checked word by word against a built-in parser model.
// Depends on ufp_pkg, ufp_stream_if and the parser RTL.

module tb_top;

    typedef struct {
        ufp_pkg::in_word_t w;
        bit                drain;
    } rx_item_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               rx_valid = 1'b0;
    ufp_pkg::in_word_t  rx_word = '0;
    logic               res_ready = 1'b0;

    ufp_stream_if #(.data_t(ufp_pkg::in_word_t))  rx_if ();
    ufp_stream_if #(.data_t(ufp_pkg::out_word_t)) res_if ();

    assign rx_if.valid  = rx_valid;
    assign rx_if.data   = rx_word;
    assign res_if.ready = res_ready;

    ubx_frame_parser_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx_ch  (rx_if.sink),
        .res_ch (res_if.source)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Parser model state.
    ufp_pkg::phase_t mdl_phase = ufp_pkg::PH_IDLE;
    logic [7:0]  mdl_sum_a = '0;
    logic [7:0]  mdl_sum_b = '0;
    logic [15:0] mdl_frame_id = '0;
    logic [15:0] mdl_left = '0;
    logic [15:0] mdl_pos = '0;
    logic [15:0] mdl_length = '0;
    logic [15:0] mdl_ack_word = '0;

    rx_item_t           rx_pending_q[$];
    ufp_pkg::out_word_t parse_expect_q[$];
    int unsigned mismatch_cnt = 0;
    int unsigned gen_count = 0;
    bit          drain_next = 1'b0;

    function automatic bit frame_is_ack();
        return (mdl_frame_id == ufp_pkg::ACK_ID_NAK) || (mdl_frame_id == ufp_pkg::ACK_ID_ACK);
    endfunction

    function automatic void fletcher_add(input logic [7:0] b);
        mdl_sum_a = mdl_sum_a + b;
        mdl_sum_b = mdl_sum_b + mdl_sum_a;
    endfunction

    function automatic ufp_pkg::out_word_t parse_byte(input ufp_pkg::in_word_t w);
        ufp_pkg::out_word_t r;
        logic [7:0]         b;
        r = '0;
        b = w.rx_byte;
        if (w.func == ufp_pkg::FUNC_RESTART)
        begin
            mdl_phase = ufp_pkg::PH_IDLE;
        end
        else
        begin
            case (mdl_phase)
                ufp_pkg::PH_SYNC1:
                begin
                    mdl_phase = (b == ufp_pkg::SYNC2) ? ufp_pkg::PH_SYNC2 : ufp_pkg::PH_IDLE;
                end
                ufp_pkg::PH_SYNC2:
                begin
                    mdl_sum_a = b;
                    mdl_sum_b = b;
                    mdl_frame_id = {b, 8'h00};
                    mdl_phase = ufp_pkg::PH_CLASS;
                end
                ufp_pkg::PH_CLASS:
                begin
                    fletcher_add(b);
                    mdl_frame_id[7:0] = b;
                    mdl_phase = ufp_pkg::PH_ID;
                end
                ufp_pkg::PH_ID:
                begin
                    fletcher_add(b);
                    mdl_left = {8'h00, b};
                    mdl_phase = ufp_pkg::PH_LEN_LO;
                end
                ufp_pkg::PH_LEN_LO:
                begin
                    fletcher_add(b);
                    mdl_left[15:8] = b;
                    mdl_pos = '0;
                    if (!frame_is_ack())
                        mdl_length = mdl_left;
                    mdl_phase = (mdl_left == 16'd0) ? ufp_pkg::PH_CK_A : ufp_pkg::PH_PAYLOAD;
                end
                ufp_pkg::PH_PAYLOAD:
                begin
                    fletcher_add(b);
                    if (frame_is_ack())
                    begin
                        if (mdl_pos == 16'd0)
                            mdl_ack_word[15:8] = b;
                        else if (mdl_pos == 16'd1)
                            mdl_ack_word[7:0] = b;
                    end
                    else
                    begin
                        r.payload_valid = 1'b1;
                        r.payload_index = mdl_pos;
                        r.payload_byte = b;
                    end
                    mdl_pos = mdl_pos + 16'd1;
                    mdl_left = mdl_left - 16'd1;
                    if (mdl_left == 16'd0)
                        mdl_phase = ufp_pkg::PH_CK_A;
                end
                ufp_pkg::PH_CK_A:
                begin
                    if (b == mdl_sum_a)
                    begin
                        mdl_phase = ufp_pkg::PH_CK_B;
                    end
                    else
                    begin
                        r.checksum_fail = 1'b1;
                        mdl_phase = ufp_pkg::PH_IDLE;
                    end
                end
                ufp_pkg::PH_CK_B:
                begin
                    if (b == mdl_sum_b)
                        r.frame_ok = 1'b1;
                    else
                        r.checksum_fail = 1'b1;
                    mdl_phase = ufp_pkg::PH_IDLE;
                end
                default:
                begin
                    mdl_phase = (b == ufp_pkg::SYNC1) ? ufp_pkg::PH_SYNC1 : ufp_pkg::PH_IDLE;
                end
            endcase
        end
        r.parse_state = mdl_phase;
        r.message_id = mdl_frame_id;
        r.frame_length = mdl_length;
        r.is_ack_frame = frame_is_ack();
        r.acked_id = mdl_ack_word;
        return r;
    endfunction

    task automatic cmp_field(input string name, input logic [15:0] e, input logic [15:0] a);
        if (e !== a)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
            mismatch_cnt++;
        end
    endtask

    // Byte driver: a random idle gap, none in calm stretches, precedes each word.
    int unsigned rx_gap = 0;
    int unsigned rx_cycle = 0;
    bit          rx_calm = 1'b0;

    always @(posedge clk)
    begin : rx_drive
        logic              next_valid;
        ufp_pkg::in_word_t next_word;
        next_valid = rx_valid;
        next_word = rx_word;
        if (rst_n)
        begin
            rx_cycle++;
            if (rx_cycle % 256 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            if (rx_valid && rx_if.ready)
            begin
                parse_expect_q.push_back(parse_byte(rx_word));
                next_valid = 1'b0;
                rx_gap = rx_calm ? 0 : $urandom_range(0, 8);
            end
            if (!next_valid)
            begin
                if (rx_gap > 0)
                begin
                    rx_gap--;
                end
                else if (rx_pending_q.size() > 0)
                begin
                    // A marked word is held back until the parser has returned everything.
                    if (!rx_pending_q[0].drain || parse_expect_q.size() == 0)
                    begin
                        next_word = rx_pending_q[0].w;
                        next_valid = 1'b1;
                        void'(rx_pending_q.pop_front());
                    end
                end
            end
        end
        rx_valid <= next_valid;
        rx_word <= next_word;
    end

    // Result monitor: after each result the receiver stalls for a random gap, none in calm stretches.
    int unsigned res_stall = 0;
    int unsigned res_cycle = 0;
    bit          res_calm = 1'b0;

    always @(posedge clk)
    begin : res_check
        ufp_pkg::out_word_t e;
        ufp_pkg::out_word_t a;
        if (rst_n)
        begin
            res_cycle++;
            if (res_cycle % 256 == 128)
                res_calm = ($urandom_range(0, 3) == 0);
            if (res_if.valid && res_ready)
            begin
                a = res_if.data;
                if (parse_expect_q.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %p", $time, a);
                    mismatch_cnt++;
                end
                else
                begin
                    e = parse_expect_q.pop_front();
                    cmp_field("parse_state", 16'(e.parse_state), 16'(a.parse_state));
                    cmp_field("frame_ok", 16'(e.frame_ok), 16'(a.frame_ok));
                    cmp_field("checksum_fail", 16'(e.checksum_fail), 16'(a.checksum_fail));
                    cmp_field("message_id", e.message_id, a.message_id);
                    cmp_field("frame_length", e.frame_length, a.frame_length);
                    cmp_field("payload_valid", 16'(e.payload_valid), 16'(a.payload_valid));
                    cmp_field("payload_index", e.payload_index, a.payload_index);
                    cmp_field("payload_byte", 16'(e.payload_byte), 16'(a.payload_byte));
                    cmp_field("is_ack_frame", 16'(e.is_ack_frame), 16'(a.is_ack_frame));
                    cmp_field("acked_id", e.acked_id, a.acked_id);
                end
                res_stall = res_calm ? 0 : $urandom_range(0, 8);
            end
            if (res_stall > 0)
            begin
                res_stall--;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    task automatic push_word(input ufp_pkg::func_t f, input logic [7:0] b);
        rx_item_t it;
        it.w.func = f;
        it.w.rx_byte = b;
        it.drain = drain_next;
        drain_next = 1'b0;
        rx_pending_q.push_back(it);
        gen_count++;
    endtask

    // fault: 0 clean, 1 bad CK_A, 2 bad CK_B, 3 restart inside the frame,
    // 4 cut short and left to whatever follows.
    task automatic push_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] len, input int fault);
        logic [7:0] hdr [0:5];
        logic [7:0] ca;
        logic [7:0] cb;
        logic [7:0] b;
        int         total;
        int         limit;
        hdr[0] = ufp_pkg::SYNC1;
        hdr[1] = ufp_pkg::SYNC2;
        hdr[2] = cls;
        hdr[3] = id;
        hdr[4] = len[7:0];
        hdr[5] = len[15:8];
        ca = '0;
        cb = '0;
        total = 8 + int'(len);
        limit = total;
        if (fault >= 3)
            limit = int'($urandom_range(1, (total - 1 < 40) ? total - 1 : 40));
        for (int k = 0; k < limit; k++)
        begin
            if (k < 6)
                b = hdr[k];
            else if (k < 6 + int'(len))
                b = 8'($urandom);
            else if (k == 6 + int'(len))
                b = ca ^ ((fault == 1) ? 8'($urandom_range(1, 255)) : 8'h00);
            else
                b = cb ^ ((fault == 2) ? 8'($urandom_range(1, 255)) : 8'h00);
            if (k >= 2 && k < 6 + int'(len))
            begin
                ca = ca + b;
                cb = cb + ca;
            end
            push_word(ufp_pkg::FUNC_DATA, b);
        end
        if (fault == 3)
            push_word(ufp_pkg::FUNC_RESTART, 8'($urandom));
    endtask

    initial
    begin : stimulus
        int          sel;
        int          fault;
        logic [7:0]  cls;
        logic [7:0]  id;
        logic [15:0] len;
        int          waited;

        // Restart while idle, a bad second sync byte, and a repeated first sync byte.
        push_word(ufp_pkg::FUNC_RESTART, 8'hFF);
        push_word(ufp_pkg::FUNC_DATA, ufp_pkg::SYNC1);
        push_word(ufp_pkg::FUNC_DATA, 8'h00);
        push_word(ufp_pkg::FUNC_DATA, ufp_pkg::SYNC1);
        push_word(ufp_pkg::FUNC_DATA, ufp_pkg::SYNC1);
        push_word(ufp_pkg::FUNC_DATA, ufp_pkg::SYNC2);
        // Zero-length payload goes straight to the checksum.
        push_frame(8'hFF, 8'h00, 16'd0, 0);
        // Acknowledge with a payload byte past the captured two.
        push_frame(ufp_pkg::ACK_ID_ACK[15:8], ufp_pkg::ACK_ID_ACK[7:0], 16'd3, 0);

        drain_next = 1'b1;
        // A payload long enough to carry the index past one byte.
        push_frame(8'h0A, 8'h33, 16'd300, 0);

        while (gen_count < 1040)
        begin
            if ($urandom_range(0, 199) == 0)
                drain_next = 1'b1;
            sel = int'($urandom_range(0, 99));
            if (sel < 8)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 5) == 0)
                        push_word(ufp_pkg::FUNC_RESTART, 8'($urandom));
                    else if ($urandom_range(0, 3) == 0)
                        push_word(ufp_pkg::FUNC_DATA, ufp_pkg::SYNC1);
                    else
                        push_word(ufp_pkg::FUNC_DATA, 8'($urandom));
                end
            end
            else
            begin
                cls = ($urandom_range(0, 3) == 0) ? ufp_pkg::ACK_ID_NAK[15:8] : 8'($urandom);
                id = 8'($urandom);
                if (cls == ufp_pkg::ACK_ID_NAK[15:8] && $urandom_range(0, 3) != 0)
                    id = 8'($urandom_range(0, 1));
                sel = int'($urandom_range(0, 99));
                fault = (sel < 70) ? 0 : (sel < 80) ? 1 : (sel < 90) ? 2 :
                        int'($urandom_range(3, 4));
                if ({cls, id} == ufp_pkg::ACK_ID_NAK || {cls, id} == ufp_pkg::ACK_ID_ACK)
                    len = 16'($urandom_range(0, 4));
                else if ($urandom_range(0, 19) == 0)
                    len = 16'($urandom_range(13, 40));
                else
                    len = 16'($urandom_range(0, 12));
                // Now and then a huge declared length, always broken off early.
                if ($urandom_range(0, 29) == 0)
                begin
                    len = 16'($urandom);
                    fault = int'($urandom_range(3, 4));
                end
                push_frame(cls, id, len, fault);
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (rx_pending_q.size() != 0 || rx_valid)
            @(posedge clk);
        waited = 0;
        while (parse_expect_q.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (5) @(posedge clk);

        if (parse_expect_q.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, parse_expect_q.size());
        if (mismatch_cnt == 0 && parse_expect_q.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
